FILE: rtl/core/rls_pkg.sv
// Package for the RMS level smoother: widths, microcode types and the control store.
package rls_pkg;

    localparam int MAX_BUFFER = 256;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 13;
    localparam int SUM_W    = 41;
    localparam int DIV_W    = SUM_W + 1;
    localparam int REM_W    = CNT_W;
    localparam int ROOT_W   = 32;
    localparam int PROD_W   = 33;
    localparam int LEVEL_W  = 16;
    localparam int BUFS_W   = 32;
    localparam int ITER_W   = 6;
    localparam int PC_W     = 4;
    localparam int ADDR_W   = 3;
    localparam int SQRT_STEPS = ROOT_W / 2;

    localparam logic [LEVEL_W-1:0] WEIGHT_RESET = 16'd4588;
    localparam logic [ROOT_W-1:0]  SQRT_FIRST_BIT = 32'h4000_0000;

    localparam logic ADDR_WEIGHT = 1'b0;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_INPUT,
        WAIT_OUTPUT
    } wait_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_SAMPLE,
        OP_SQUARE,
        OP_ACCUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_MIX_HIGH,
        OP_MIX_LOW,
        OP_MIX_SUM,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_OPEN,
        JMP_IF_MORE
    } jump_t;

    typedef struct packed {
        wait_t            wt;
        dp_op_t           op;
        jump_t            jmp;
        logic [PC_W-1:0]  target;
    } ucode_t;

    localparam logic [PC_W-1:0] PC_WAIT_SAMPLE = 4'd0;
    localparam logic [PC_W-1:0] PC_DIV_STEP    = 4'd5;
    localparam logic [PC_W-1:0] PC_SQRT_STEP   = 4'd7;

    // Control store: one word per step of the sequencer.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            4'd0:    w = '{WAIT_INPUT,  OP_LOAD_SAMPLE, JMP_NEXT,    PC_WAIT_SAMPLE};
            4'd1:    w = '{WAIT_NONE,   OP_SQUARE,      JMP_NEXT,    PC_WAIT_SAMPLE};
            4'd2:    w = '{WAIT_NONE,   OP_ACCUM,       JMP_NEXT,    PC_WAIT_SAMPLE};
            4'd3:    w = '{WAIT_NONE,   OP_NOP,         JMP_IF_OPEN, PC_WAIT_SAMPLE};
            4'd4:    w = '{WAIT_NONE,   OP_DIV_INIT,    JMP_NEXT,    PC_WAIT_SAMPLE};
            4'd5:    w = '{WAIT_NONE,   OP_DIV_STEP,    JMP_IF_MORE, PC_DIV_STEP};
            4'd6:    w = '{WAIT_NONE,   OP_SQRT_INIT,   JMP_NEXT,    PC_WAIT_SAMPLE};
            4'd7:    w = '{WAIT_NONE,   OP_SQRT_STEP,   JMP_IF_MORE, PC_SQRT_STEP};
            4'd8:    w = '{WAIT_NONE,   OP_MIX_HIGH,    JMP_NEXT,    PC_WAIT_SAMPLE};
            4'd9:    w = '{WAIT_NONE,   OP_MIX_LOW,     JMP_NEXT,    PC_WAIT_SAMPLE};
            4'd10:   w = '{WAIT_NONE,   OP_MIX_SUM,     JMP_NEXT,    PC_WAIT_SAMPLE};
            4'd11:   w = '{WAIT_OUTPUT, OP_EMIT,        JMP_ALWAYS,  PC_WAIT_SAMPLE};
            default: w = '{WAIT_NONE,   OP_NOP,         JMP_ALWAYS,  PC_WAIT_SAMPLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/rms_level_smoother.sv
// RMS level meter with exponential smoothing, run by a microcoded sequencer.
//
// Input stream: s_tdata carries one signed Q1.15 audio sample, s_tlast marks the last
// sample of a buffer. A buffer also closes on its MAX_BUFFER-th sample.
// Output stream: one transaction per closed buffer with the buffer's RMS level, the
// smoothed level and the count of closed buffers (wrapping at 2^32).
// The APB port holds the smoothing weight (Q0.16) at byte address 0.
//
// After a sample is accepted, s_tready stays low until the sequencer has finished
// with it, so the block takes no new sample before it is through with the last. The
// result of a closed buffer comes from a bit-serial divider for the mean and a
// bit-serial square root, both sharing one sequencer with a 16x17 multiplier.
// The block holds one result in its output register. If the receiver stalls, the
// sequencer goes on accepting samples and waits at its output step only when a new
// result is ready before the held one has been taken.
// Reset clears the running sum, the sample count, the smoothed level, the buffer count
// and the output valid flag, and restores the weight to 4588 (about 0.07).
module rms_level_smoother
    import rls_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] sample
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // [15:0] rms_level, [31:16] smoothed_level,
                                         // [63:32] buffer_number
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [SAMPLE_W-1:0] mag_reg, mag_next;
    logic                last_reg, last_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]    dvd_reg, dvd_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   x_reg, x_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W-1:0]   bit_reg, bit_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [BUFS_W-1:0]   bufs_reg, bufs_next;
    logic [LEVEL_W-1:0]  weight_reg, weight_next;
    logic                out_valid_reg, out_valid_next;
    logic [63:0]         out_data_reg, out_data_next;

    ucode_t              uword;
    logic                go;
    logic                close_buf;
    logic                more;
    logic                cfg_write;
    logic [SAMPLE_W-1:0] sample_mag;
    logic [REM_W:0]      div_trial;
    logic                div_ge;
    logic [ROOT_W-1:0]   sqrt_trial;
    logic                sqrt_ge;
    logic [LEVEL_W:0]    weight_cmp;
    logic [PROD_W:0]     mix_sum;

    assign uword = ucode_rom(pc_reg);

    always_comb begin
        unique case (uword.wt)
            WAIT_NONE:   go = 1'b1;
            WAIT_INPUT:  go = s_tvalid;
            WAIT_OUTPUT: go = !out_valid_reg || m_tready;
            default:     go = 1'b0;
        endcase
    end

    assign s_tready  = (uword.wt == WAIT_INPUT);
    assign close_buf = last_reg || (cnt_reg == CNT_W'(MAX_BUFFER));
    assign more      = (iter_reg != ITER_W'(1));

    // Sequencer: step counter with conditional jumps from the control word.
    always_comb begin
        pc_next = pc_reg;
        if (go) begin
            unique case (uword.jmp)
                JMP_NEXT:    pc_next = pc_reg + PC_W'(1);
                JMP_ALWAYS:  pc_next = uword.target;
                JMP_IF_OPEN: pc_next = close_buf ? pc_reg + PC_W'(1) : uword.target;
                JMP_IF_MORE: pc_next = more ? uword.target : pc_reg + PC_W'(1);
                default:     pc_next = uword.target;
            endcase
        end
    end

    assign sample_mag = s_tdata[15] ? SAMPLE_W'(17'h10000 - {1'b0, s_tdata}) : s_tdata;
    assign div_trial  = {rem_reg, dvd_reg[DIV_W-1]};
    assign div_ge     = div_trial >= {1'b0, cnt_reg};
    assign sqrt_trial = root_reg + bit_reg;
    assign sqrt_ge    = x_reg >= sqrt_trial;
    assign weight_cmp = 17'h10000 - {1'b0, weight_reg};
    assign mix_sum    = {1'b0, acc_reg} + {1'b0, prod_reg};

    assign cfg_write = psel && penable && pwrite && pready;

    // Datapath: each control word selects one operation.
    always_comb begin
        iter_next      = iter_reg;
        mag_next       = mag_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        x_next         = x_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        level_next     = level_reg;
        bufs_next      = bufs_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        weight_next    = weight_reg;

        if (cfg_write && paddr[2] == ADDR_WEIGHT) begin
            weight_next = pwdata[LEVEL_W-1:0];
        end

        if (go) begin
            unique case (uword.op)
                OP_NOP: begin
                end
                OP_LOAD_SAMPLE: begin
                    mag_next  = sample_mag;
                    last_next = s_tlast;
                end
                OP_SQUARE: begin
                    prod_next = PROD_W'(mag_reg) * PROD_W'(mag_reg);
                end
                OP_ACCUM: begin
                    sum_next = sum_reg + SUM_W'(prod_reg[31:2]);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                OP_DIV_INIT: begin
                    dvd_next  = {sum_reg, 1'b0};
                    rem_next  = '0;
                    iter_next = ITER_W'(DIV_W);
                end
                OP_DIV_STEP: begin
                    // Restoring division, one quotient bit per step shifted in at the bottom.
                    rem_next  = div_ge ? REM_W'(div_trial - {1'b0, cnt_reg})
                                       : div_trial[REM_W-1:0];
                    dvd_next  = {dvd_reg[DIV_W-2:0], div_ge};
                    iter_next = iter_reg - ITER_W'(1);
                end
                OP_SQRT_INIT: begin
                    // The mean square never exceeds 2^29, so 32 bits of quotient suffice.
                    x_next    = dvd_reg[ROOT_W-1:0];
                    root_next = '0;
                    bit_next  = SQRT_FIRST_BIT;
                    iter_next = ITER_W'(SQRT_STEPS);
                end
                OP_SQRT_STEP: begin
                    if (sqrt_ge) begin
                        x_next    = x_reg - sqrt_trial;
                        root_next = (root_reg >> 1) + bit_reg;
                    end else begin
                        root_next = root_reg >> 1;
                    end
                    bit_next  = bit_reg >> 2;
                    iter_next = iter_reg - ITER_W'(1);
                end
                OP_MIX_HIGH: begin
                    prod_next = PROD_W'(level_reg) * PROD_W'(weight_cmp);
                end
                OP_MIX_LOW: begin
                    acc_next  = prod_reg;
                    prod_next = PROD_W'(root_reg[LEVEL_W-1:0]) * PROD_W'(weight_reg);
                end
                OP_MIX_SUM: begin
                    level_next = mix_sum[31:16];
                    bufs_next  = bufs_reg + BUFS_W'(1);
                    sum_next   = '0;
                    cnt_next   = '0;
                end
                OP_EMIT: begin
                    out_data_next  = {bufs_reg, level_reg, root_reg[LEVEL_W-1:0]};
                    out_valid_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= PC_WAIT_SAMPLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            level_reg     <= '0;
            bufs_reg      <= '0;
            weight_reg    <= WEIGHT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            level_reg     <= level_next;
            bufs_reg      <= bufs_next;
            weight_reg    <= weight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg     <= iter_next;
        mag_reg      <= mag_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        x_reg        <= x_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ADDR_WEIGHT) ? {16'b0, weight_reg} : 32'b0;

endmodule

FILE: rtl/core/rls_checker.sv
// Port-level checks for the RMS level smoother, bound to the top level.
module rls_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [63:0]       m_tdata
);

    // A stalled result must stay in place until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // The block works on one sample at a time.
    a_one_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted sample");

    // A result never appears in the cycle right after a sample is taken.
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result produced too soon after a sample");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rms_level_smoother rls_checker u_rls_checker (.*);
